/* rtl/stwa_pkg.sv */
// Shared types, widths and codes of the session table with aging.
package stwa_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SCAN_W  = $clog2(ENTRIES + 1);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 50;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 8;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int OUT_W   = 7;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Configuration register indexes.
    localparam logic REG_EXPIRY_TIMEOUT = 1'b0;
    localparam logic REG_DRAIN_RATE     = 1'b1;

    localparam logic [CFG_W-1:0] EXPIRY_TIMEOUT_RST = 8'd30;
    localparam logic [CFG_W-1:0] DRAIN_RATE_RST     = 8'd10;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_ACTIVE    = 3'd4;
    localparam logic [STAT_W-1:0] ST_INACTIVE  = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;
    localparam logic [STAT_W-1:0] ST_DONE      = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] seen;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

endpackage

/* rtl/session_table_with_aging_top.sv */
// Session table with timeout aging: command sequencer over one entry memory.
//
// Input channel: one beat carries a command (cmd) and a subscriber key (imsi).
// A beat is taken when in_valid is high and in_stall is low. Output channel:
// one result beat per command with status, count and occupancy, taken when
// out_valid is high and out_stall is low.
// Add, remove, query, sweep and drain walk every entry through the single
// read port, one per cycle, before the commit step. Tick and the unused
// codes skip the walk and go straight to the commit step. One command is
// in flight at a time; in_stall is high from acceptance until its result
// has been moved into the output register.
// The output register holds a finished result while the receiver stalls;
// the next command is taken meanwhile and waits at its commit step until the
// output register is free.
// Reset clears the valid marks, the seconds counter, the live count and the
// output valid, and restores the timeout to 30 and the drain rate to 10.
// Memory contents are not cleared: an entry is only trusted when its valid
// mark is set, so there is no clearing pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant to be issued while the block is idle.
module session_table_with_aging_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [stwa_pkg::CMD_W-1:0]    cmd,
    input  logic [stwa_pkg::KEY_W-1:0]    imsi,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stwa_pkg::STAT_W-1:0]   status,
    output logic [stwa_pkg::OUT_W-1:0]    count,
    output logic [stwa_pkg::OUT_W-1:0]    occupancy,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [stwa_pkg::CFG_W-1:0]    cfg_data
);

    // Control state
    stwa_pkg::state_t                 state_reg, state_next;
    logic [stwa_pkg::ENTRIES-1:0]     valid_reg, valid_next;
    logic [stwa_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [stwa_pkg::CNT_W-1:0]       live_reg, live_next;
    logic [stwa_pkg::CFG_W-1:0]       timeout_reg;
    logic [stwa_pkg::CFG_W-1:0]       drain_rate_reg;
    logic [stwa_pkg::SCAN_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                             pend_reg, pend_next;
    logic [stwa_pkg::IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                             found_reg, found_next;
    logic [stwa_pkg::IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                             free_found_reg, free_found_next;
    logic [stwa_pkg::IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [stwa_pkg::CNT_W-1:0]       removed_reg, removed_next;
    logic                             out_valid_reg, out_valid_next;

    // Payload registers
    logic [stwa_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [stwa_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [stwa_pkg::STAT_W-1:0]      status_reg, status_next;
    logic [stwa_pkg::OUT_W-1:0]       count_reg, count_next;
    logic [stwa_pkg::OUT_W-1:0]       occ_reg, occ_next;

    // Entry memory: one write port, one registered read port
    stwa_pkg::entry_t                 mem [stwa_pkg::ENTRIES];
    stwa_pkg::entry_t                 rd_data_reg;
    logic                             rd_en;
    logic [stwa_pkg::IDX_W-1:0]       rd_addr;
    logic                             mem_we;
    logic [stwa_pkg::IDX_W-1:0]       mem_waddr;
    stwa_pkg::entry_t                 mem_wdata;

    logic                             out_free;
    logic                             is_scan_cmd;
    logic                             pend_live;
    logic [stwa_pkg::TIME_W-1:0]      age;

    assign in_stall  = (state_reg != stwa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign occupancy = occ_reg;

    assign out_free  = !out_valid_reg || !out_stall;

    // Commands that need a walk over the table
    assign is_scan_cmd = (cmd == stwa_pkg::CMD_ADD)   || (cmd == stwa_pkg::CMD_REMOVE) ||
                         (cmd == stwa_pkg::CMD_QUERY) || (cmd == stwa_pkg::CMD_SWEEP)  ||
                         (cmd == stwa_pkg::CMD_DRAIN);

    assign pend_live = valid_reg[pend_idx_reg];
    assign age       = now_reg - rd_data_reg.seen;

    // Memory writes happen only at the commit step, after the walk has
    // finished, so a read never overlaps a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        now_next        = now_reg;
        live_next       = live_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        occ_next        = occ_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_idx_reg[stwa_pkg::IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = hit_idx_reg;
        mem_wdata.key   = key_reg;
        mem_wdata.seen  = now_reg;

        // Retire the held result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            stwa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    key_next        = imsi;
                    scan_idx_next   = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    state_next      = is_scan_cmd ? stwa_pkg::S_SCAN : stwa_pkg::S_COMMIT;
                end
            end

            stwa_pkg::S_SCAN:
            begin
                // Evaluate the entry whose read came back this cycle
                if (pend_reg)
                begin
                    case (cmd_reg)
                        stwa_pkg::CMD_ADD,
                        stwa_pkg::CMD_REMOVE,
                        stwa_pkg::CMD_QUERY:
                        begin
                            if (pend_live && !found_reg && (rd_data_reg.key == key_reg))
                            begin
                                found_next   = 1'b1;
                                hit_idx_next = pend_idx_reg;
                            end
                            if (!pend_live && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = pend_idx_reg;
                            end
                        end
                        stwa_pkg::CMD_SWEEP:
                        begin
                            if (pend_live && (age > stwa_pkg::TIME_W'(timeout_reg)))
                            begin
                                valid_next[pend_idx_reg] = 1'b0;
                                live_next                = live_reg - 1'b1;
                                removed_next             = removed_reg + 1'b1;
                            end
                        end
                        stwa_pkg::CMD_DRAIN:
                        begin
                            if (pend_live && (stwa_pkg::CMP_W'(removed_reg) <
                                              stwa_pkg::CMP_W'(drain_rate_reg)))
                            begin
                                valid_next[pend_idx_reg] = 1'b0;
                                live_next                = live_reg - 1'b1;
                                removed_next             = removed_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // Issue the next read, or finish once the last one is used
                if (scan_idx_reg != stwa_pkg::SCAN_W'(stwa_pkg::ENTRIES))
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[stwa_pkg::IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = stwa_pkg::S_COMMIT;
                    end
                end
            end

            stwa_pkg::S_COMMIT:
            begin
                if (out_free)
                begin
                    status_next = stwa_pkg::ST_DONE;
                    case (cmd_reg)
                        stwa_pkg::CMD_ADD:
                        begin
                            if (found_reg)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = hit_idx_reg;
                                status_next = stwa_pkg::ST_REFRESHED;
                            end
                            else if (free_found_reg)
                            begin
                                mem_we                    = 1'b1;
                                mem_waddr                 = free_idx_reg;
                                valid_next[free_idx_reg]  = 1'b1;
                                live_next                 = live_reg + 1'b1;
                                status_next               = stwa_pkg::ST_ADDED;
                            end
                            else
                            begin
                                status_next = stwa_pkg::ST_FULL;
                            end
                        end
                        stwa_pkg::CMD_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                live_next               = live_reg - 1'b1;
                                status_next             = stwa_pkg::ST_REMOVED;
                            end
                            else
                            begin
                                status_next = stwa_pkg::ST_NOT_FOUND;
                            end
                        end
                        stwa_pkg::CMD_QUERY:
                        begin
                            status_next = found_reg ? stwa_pkg::ST_ACTIVE
                                                    : stwa_pkg::ST_INACTIVE;
                        end
                        stwa_pkg::CMD_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    count_next     = stwa_pkg::OUT_W'(removed_reg);
                    occ_next       = stwa_pkg::OUT_W'(live_next);
                    out_valid_next = 1'b1;
                    state_next     = stwa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = stwa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stwa_pkg::S_IDLE;
            valid_reg      <= '0;
            now_reg        <= '0;
            live_reg       <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            now_reg        <= now_next;
            live_reg       <= live_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            removed_reg    <= removed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= stwa_pkg::EXPIRY_TIMEOUT_RST;
            drain_rate_reg <= stwa_pkg::DRAIN_RATE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == stwa_pkg::REG_EXPIRY_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_index == stwa_pkg::REG_DRAIN_RATE)
            begin
                drain_rate_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
        occ_reg      <= occ_next;
    end

endmodule

/* rtl/stwa_checker.sv */
// Port-level checks of the session table with aging, bound to the top level.
module stwa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [stwa_pkg::STAT_W-1:0]   status,
    input logic [stwa_pkg::OUT_W-1:0]    count,
    input logic [stwa_pkg::OUT_W-1:0]    occupancy
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count) &&
                                   $stable(occupancy))
        else $error("stalled result beat changed");

    // One command at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a command is in flight");

    // Occupancy never exceeds the table size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= stwa_pkg::OUT_W'(stwa_pkg::ENTRIES))
        else $error("occupancy beyond table size");

    // Keyed commands remove nothing in bulk
    a_keyed_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == stwa_pkg::ST_ADDED || status == stwa_pkg::ST_REFRESHED ||
                      status == stwa_pkg::ST_REMOVED || status == stwa_pkg::ST_NOT_FOUND ||
                      status == stwa_pkg::ST_ACTIVE || status == stwa_pkg::ST_INACTIVE ||
                      status == stwa_pkg::ST_FULL) |-> count == '0)
        else $error("non-zero count on a keyed command");

    // Full is only reported with every slot taken
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == stwa_pkg::ST_FULL |->
            occupancy == stwa_pkg::OUT_W'(stwa_pkg::ENTRIES))
        else $error("full reported with free slots");

endmodule

bind session_table_with_aging_top stwa_checker u_stwa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .count     (count),
    .occupancy (occupancy)
);

/* tb/session_table_with_aging_top_tb.sv */
// Self-checking testbench of the session table with aging: directed script, then random traffic.
module session_table_with_aging_top_tb;

    import stwa_pkg::*;

    // Clock period is 20 units. The global limit lies well beyond the slowest legal
    // run (~930 beats, each a full table walk at most, plus stalls and gaps).
    localparam int HALF_PERIOD   = 10;
    localparam int LIMIT_UNITS   = 20_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES   = 80;
    localparam int POOL_MAX      = 100;

    // Unused command codes: the block answers them with done and changes nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] DEC_MAX = 50'd999999999999999;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  count;
        logic [OUT_W-1:0]  occupancy;
    } outcome_t;

    // Per-beat tag: whether the script pins the expected outcome.
    typedef struct packed {
        bit       pin;
        outcome_t res;
    } beat_tag_t;

    typedef struct packed {
        bit                is_write;
        logic [CMD_W-1:0]  op;
        logic [KEY_W-1:0]  key;
        bit                pin;
        outcome_t          res;
        logic              reg_idx;
        logic [CFG_W-1:0]  reg_val;
    } script_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd       = '0;
    logic [KEY_W-1:0]    imsi      = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [OUT_W-1:0]    count;
    logic [OUT_W-1:0]    occupancy;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // Shadow copy of the session table, kept in step with every accepted beat.
    logic [KEY_W-1:0]    tbl_key  [ENTRIES];
    logic [TIME_W-1:0]   tbl_seen [ENTRIES];
    bit   [ENTRIES-1:0]  tbl_mark    = '0;
    logic [TIME_W-1:0]   tbl_now     = '0;
    int                  tbl_live    = 0;
    logic [CFG_W-1:0]    tbl_timeout = EXPIRY_TIMEOUT_RST;
    logic [CFG_W-1:0]    tbl_drain   = DRAIN_RATE_RST;

    outcome_t            awaited_results [$];
    beat_tag_t           beat_tags [$];
    script_row_t         script [$];
    logic [KEY_W-1:0]    key_pool [POOL_MAX];

    int                  errs      = 0;
    int                  seen_cnt  = 0;
    bit                  hold_req  = 1'b0;
    bit                  quiet     = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    session_table_with_aging_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .imsi      (imsi),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count),
        .occupancy (occupancy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $time, what);
        errs++;
    endtask

    function automatic int find_session(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_mark[i] && tbl_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic int find_vacant();
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!tbl_mark[i])
                return i;
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and return what the block must answer.
    function automatic outcome_t session_outcome(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
        outcome_t          o;
        int                slot;
        int                gone;
        logic [TIME_W-1:0] age;
        o.status = ST_DONE;
        gone = 0;
        case (c)
            CMD_ADD:
            begin
                slot = find_session(k);
                if (slot >= 0)
                begin
                    tbl_seen[slot] = tbl_now;
                    o.status = ST_REFRESHED;
                end
                else
                begin
                    slot = find_vacant();
                    if (slot >= 0)
                    begin
                        tbl_key[slot]  = k;
                        tbl_seen[slot] = tbl_now;
                        tbl_mark[slot] = 1'b1;
                        tbl_live++;
                        o.status = ST_ADDED;
                    end
                    else
                        o.status = ST_FULL;
                end
            end
            CMD_REMOVE:
            begin
                slot = find_session(k);
                if (slot >= 0)
                begin
                    tbl_mark[slot] = 1'b0;
                    tbl_live--;
                    o.status = ST_REMOVED;
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            CMD_QUERY:
                o.status = (find_session(k) >= 0) ? ST_ACTIVE : ST_INACTIVE;
            CMD_TICK:
                tbl_now = tbl_now + 1'b1;
            CMD_SWEEP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_mark[i])
                    begin
                        // age is modular, so a wrapped counter still ages correctly
                        age = tbl_now - tbl_seen[i];
                        if (age > {{(TIME_W-CFG_W){1'b0}}, tbl_timeout})
                        begin
                            tbl_mark[i] = 1'b0;
                            tbl_live--;
                            gone++;
                        end
                    end
                end
            end
            CMD_DRAIN:
            begin
                // lowest slots go first; a drain rate of zero removes nothing
                for (int i = 0; i < ENTRIES && gone < int'(tbl_drain); i++)
                begin
                    if (tbl_mark[i])
                    begin
                        tbl_mark[i] = 1'b0;
                        tbl_live--;
                        gone++;
                    end
                end
            end
            default: ;
        endcase
        o.count     = gone[OUT_W-1:0];
        o.occupancy = tbl_live[OUT_W-1:0];
        return o;
    endfunction

    // Monitor: sample both channels and the write port on the rising edge, where the
    // values seen are those that stood before the edge.
    always @(posedge clk)
    begin
        beat_tag_t tag;
        outcome_t  want;
        outcome_t  guess;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_cnt++;
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing awaited", seen_cnt));
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status || count !== want.count
                        || occupancy !== want.occupancy)
                        report_mismatch($sformatf(
                            "result %0d status %0d/%0d count %0d/%0d occupancy %0d/%0d",
                            seen_cnt, status, want.status, count, want.count,
                            occupancy, want.occupancy));
                end
            end
            if (in_valid && !in_stall)
            begin
                guess = session_outcome(cmd, imsi);
                if (beat_tags.size() != 0)
                begin
                    tag = beat_tags.pop_front();
                    awaited_results.push_back(tag.pin ? tag.res : guess);
                end
                else
                    awaited_results.push_back(guess);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_EXPIRY_TIMEOUT)
                    tbl_timeout = cfg_data;
                else
                    tbl_drain = cfg_data;
            end
        end
    end

    // Receiver: stall in random bursts, honour a long hold on request, go quiet at the end.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    function automatic outcome_t outcome(logic [STAT_W-1:0] st, int cnt, int occ);
        outcome_t o;
        o.status    = st;
        o.count     = cnt[OUT_W-1:0];
        o.occupancy = occ[OUT_W-1:0];
        return o;
    endfunction

    function automatic void beat_pinned(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                        logic [STAT_W-1:0] st, int cnt, int occ);
        script_row_t r;
        r = '0;
        r.op  = c;
        r.key = k;
        r.pin = 1'b1;
        r.res = outcome(st, cnt, occ);
        script.push_back(r);
    endfunction

    function automatic void beat_free(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k);
        script_row_t r;
        r = '0;
        r.op  = c;
        r.key = k;
        script.push_back(r);
    endfunction

    function automatic void write_row(logic idx, logic [CFG_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        script.push_back(r);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[KEY_W-1:0];
    endfunction

    // Mostly keys from the pool so that adds, refreshes and lookups hit; the rest
    // are wide random keys and the extremes.
    function automatic logic [KEY_W-1:0] pick_key(int pool_n);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return rand_key();
        if (r == 1)
            return ($urandom_range(0, 1) != 0) ? KEY_MAX : DEC_MAX;
        return key_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(int add_w, int tick_w);
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < add_w)
            return CMD_ADD;
        if (r < add_w + tick_w)
            return CMD_TICK;
        s = $urandom_range(0, 47);
        if (s < 15)
            return CMD_REMOVE;
        if (s < 35)
            return CMD_QUERY;
        if (s < 41)
            return CMD_SWEEP;
        if (s < 44)
            return CMD_DRAIN;
        return s[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    // Offer one beat and hold it until the block takes it. Valid stays high on return
    // so that a following beat can go out back to back.
    task automatic push_beat(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, bit pin, outcome_t res);
        beat_tag_t tag;
        tag.pin = pin;
        tag.res = res;
        beat_tags.push_back(tag);
        in_valid <= 1'b1;
        cmd      <= c;
        imsi     <= k;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Drop valid and wait until every awaited result has been taken.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while ((awaited_results.size() != 0 || beat_tags.size() != 0) && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block idle; the write lands at the next edge.
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(int beats, logic [CFG_W-1:0] tmo, logic [CFG_W-1:0] drn,
                               int add_w, int tick_w, int pool_n, bit hush, bit squeeze);
        settle();
        write_reg(REG_EXPIRY_TIMEOUT, tmo);
        write_reg(REG_DRAIN_RATE, drn);
        quiet = hush;
        // hold the receiver off while the sender keeps offering, so the block backs up
        if (squeeze)
            hold_req = 1'b1;
        for (int i = 0; i < beats; i++)
        begin
            push_beat(pick_cmd(add_w, tick_w), pick_key(pool_n), 1'b0, '0);
            if (!hush && i % 60 == 59)
                settle();
            else if (!hush && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    endtask

    // Global limit: a run that gets here has hung.
    initial
    begin
        #(LIMIT_UNITS);
        $display("[session_table_with_aging_top] ERROR");
        $finish;
    end

    initial
    begin
        script_row_t row;

        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = rand_key();
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        key_pool[2] = DEC_MAX;

        // Directed script: lookups on an empty table, extreme keys, refresh, spare codes,
        // expiry with a zero timeout, drain order, a zero drain rate and the extremes.
        beat_pinned(CMD_QUERY,  50'd5,   ST_INACTIVE,  0, 0);
        beat_pinned(CMD_REMOVE, 50'd5,   ST_NOT_FOUND, 0, 0);
        beat_pinned(CMD_DRAIN,  KEY_MAX, ST_DONE,      0, 0);
        beat_pinned(CMD_SWEEP,  '0,      ST_DONE,      0, 0);
        beat_pinned(CMD_ADD,    '0,      ST_ADDED,     0, 1);
        beat_pinned(CMD_ADD,    KEY_MAX, ST_ADDED,     0, 2);
        beat_pinned(CMD_ADD,    DEC_MAX, ST_ADDED,     0, 3);
        beat_pinned(CMD_ADD,    '0,      ST_REFRESHED, 0, 3);
        beat_pinned(CMD_QUERY,  KEY_MAX, ST_ACTIVE,    0, 3);
        beat_pinned(CMD_QUERY,  50'd1,   ST_INACTIVE,  0, 3);
        beat_pinned(CMD_TICK,   DEC_MAX, ST_DONE,      0, 3);
        beat_pinned(CMD_SWEEP,  '0,      ST_DONE,      0, 3);
        beat_pinned(CMD_SPARE_LO, KEY_MAX, ST_DONE,    0, 3);
        beat_pinned(CMD_SPARE_HI, '0,    ST_DONE,      0, 3);
        write_row(REG_EXPIRY_TIMEOUT, 8'd0);
        beat_pinned(CMD_ADD,    '0,      ST_REFRESHED, 0, 3);
        beat_free(CMD_SWEEP, '0);
        beat_pinned(CMD_TICK,   '0,      ST_DONE,      0, 1);
        beat_pinned(CMD_ADD,    50'd123, ST_ADDED,     0, 2);
        write_row(REG_DRAIN_RATE, 8'd1);
        beat_free(CMD_DRAIN, '0);
        beat_pinned(CMD_QUERY,  '0,      ST_INACTIVE,  0, 1);
        beat_pinned(CMD_QUERY,  50'd123, ST_ACTIVE,    0, 1);
        write_row(REG_DRAIN_RATE, 8'd0);
        beat_pinned(CMD_DRAIN,  '0,      ST_DONE,      0, 1);
        write_row(REG_EXPIRY_TIMEOUT, 8'd255);
        write_row(REG_DRAIN_RATE, 8'd255);
        beat_pinned(CMD_SWEEP,  '0,      ST_DONE,      0, 1);
        beat_pinned(CMD_DRAIN,  '0,      ST_DONE,      1, 0);
        beat_pinned(CMD_REMOVE, 50'd123, ST_NOT_FOUND, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // walk the script; writes wait for the block to drain first
        for (int i = 0; i < script.size(); i++)
        begin
            row = script[i];
            if (row.is_write)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                push_beat(row.op, row.key, row.pin, row.res);
        end

        // Random traffic. A mixed run first, then the fill phase: long timeout, heavy adds over
        // a pool wider than the table so that it runs full, with the receiver held off at the start.
        run_traffic(200, 8'd30,  8'd10, 45, 10, 48,  1'b0, 1'b0);
        run_traffic(180, 8'd255, 8'd2,  75, 2,  100, 1'b0, 1'b1);
        // fast ageing: sessions expire on every sweep after a tick
        run_traffic(180, 8'd0,   8'd1,  40, 25, 32,  1'b0, 1'b0);
        run_traffic(160, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 20)),
                    50, 20, 70, 1'b0, 1'b0);
        // last stretch: no idling on either side
        run_traffic(180, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    50, 15, 64, 1'b1, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (errs == 0)
            $display("[session_table_with_aging_top] OK");
        else
            $display("[session_table_with_aging_top] ERROR");
        $finish;
    end

endmodule
